// ===== hdl/gyro_quaternion_integrator_defines.svh =====
// assertion macros for the sequencer of the gyro quaternion integrator
`ifndef GYRO_QUATERNION_INTEGRATOR_DEFINES_SVH
`define GYRO_QUATERNION_INTEGRATOR_DEFINES_SVH

// same-cycle implication, checked on clk with rst_n low as disable
`define GQI_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GQI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gqi_pkg.sv =====
// types, constants and the multiply schedule of the gyro quaternion integrator
package gqi_pkg;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] MUL_LAST  = 5'd24;
    localparam logic [STEP_W-1:0] SQRT_LAST = 5'd31;
    localparam logic [STEP_W-1:0] DIV_LAST  = 5'd30;

    localparam logic signed [31:0] QONE     = 32'sh4000_0000;
    localparam logic [46:0]        HALF_MAX = 47'h0000_1000_0000;

    typedef enum logic [2:0] {
        REG_BIAS_X,
        REG_BIAS_Y,
        REG_BIAS_Z,
        REG_RATE_SCALE,
        REG_DEADBAND,
        REG_TIME_STEP
    } reg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_ACC,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV,
        OP_WRITE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef enum logic [2:0] {
        K_SCALE,
        K_TLO,
        K_THI,
        K_QUAT,
        K_SQUARE
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [1:0] a_idx;
        logic [1:0] d_idx;
        logic       neg;
        logic [1:0] comp;
    } plan_t;

    function automatic plan_t mk(input kind_t k, input logic [1:0] a, input logic [1:0] d,
                                 input logic n, input logic [1:0] c);
        plan_t p;
        p.kind  = k;
        p.a_idx = a;
        p.d_idx = d;
        p.neg   = n;
        p.comp  = c;
        return p;
    endfunction

    // per step: three products per axis, twelve quaternion terms, four squares
    function automatic plan_t mul_plan(input logic [STEP_W-1:0] step);
        plan_t p;
        case (step)
            5'd0:    p = mk(K_SCALE,  2'd0, 2'd0, 1'b0, 2'd0);
            5'd1:    p = mk(K_TLO,    2'd0, 2'd0, 1'b0, 2'd0);
            5'd2:    p = mk(K_THI,    2'd0, 2'd0, 1'b0, 2'd0);
            5'd3:    p = mk(K_SCALE,  2'd1, 2'd0, 1'b0, 2'd0);
            5'd4:    p = mk(K_TLO,    2'd1, 2'd0, 1'b0, 2'd0);
            5'd5:    p = mk(K_THI,    2'd1, 2'd0, 1'b0, 2'd0);
            5'd6:    p = mk(K_SCALE,  2'd2, 2'd0, 1'b0, 2'd0);
            5'd7:    p = mk(K_TLO,    2'd2, 2'd0, 1'b0, 2'd0);
            5'd8:    p = mk(K_THI,    2'd2, 2'd0, 1'b0, 2'd0);
            5'd9:    p = mk(K_QUAT,   2'd1, 2'd0, 1'b1, 2'd0);
            5'd10:   p = mk(K_QUAT,   2'd2, 2'd1, 1'b1, 2'd0);
            5'd11:   p = mk(K_QUAT,   2'd3, 2'd2, 1'b1, 2'd0);
            5'd12:   p = mk(K_QUAT,   2'd0, 2'd0, 1'b0, 2'd1);
            5'd13:   p = mk(K_QUAT,   2'd2, 2'd2, 1'b0, 2'd1);
            5'd14:   p = mk(K_QUAT,   2'd3, 2'd1, 1'b1, 2'd1);
            5'd15:   p = mk(K_QUAT,   2'd0, 2'd1, 1'b0, 2'd2);
            5'd16:   p = mk(K_QUAT,   2'd1, 2'd2, 1'b1, 2'd2);
            5'd17:   p = mk(K_QUAT,   2'd3, 2'd0, 1'b0, 2'd2);
            5'd18:   p = mk(K_QUAT,   2'd0, 2'd2, 1'b0, 2'd3);
            5'd19:   p = mk(K_QUAT,   2'd1, 2'd1, 1'b0, 2'd3);
            5'd20:   p = mk(K_QUAT,   2'd2, 2'd0, 1'b1, 2'd3);
            5'd21:   p = mk(K_SQUARE, 2'd0, 2'd0, 1'b0, 2'd0);
            5'd22:   p = mk(K_SQUARE, 2'd1, 2'd0, 1'b0, 2'd1);
            5'd23:   p = mk(K_SQUARE, 2'd2, 2'd0, 1'b0, 2'd2);
            default: p = mk(K_SQUARE, 2'd3, 2'd0, 1'b0, 2'd3);
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/gqi_ctrl.sv =====
// sequencer of the gyro quaternion integrator
`include "gyro_quaternion_integrator_defines.svh"

module gqi_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output gqi_pkg::cmd_t cmd
);

    gqi_pkg::state_t state_reg, state_next;
    logic [gqi_pkg::STEP_W-1:0] step_reg, step_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gqi_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = gqi_pkg::OP_NONE;
        cmd.step       = step_reg;
        case (state_reg)
            gqi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = gqi_pkg::OP_LOAD;
                    state_next = gqi_pkg::ST_MUL;
                    step_next  = '0;
                end
            end
            gqi_pkg::ST_MUL:
            begin
                cmd.op     = gqi_pkg::OP_MUL;
                state_next = gqi_pkg::ST_ACC;
            end
            gqi_pkg::ST_ACC:
            begin
                cmd.op = gqi_pkg::OP_ACC;
                if (step_reg == gqi_pkg::MUL_LAST)
                begin
                    state_next = gqi_pkg::ST_SQRT_INIT;
                end
                else
                begin
                    state_next = gqi_pkg::ST_MUL;
                    step_next  = step_reg + 1'b1;
                end
            end
            gqi_pkg::ST_SQRT_INIT:
            begin
                cmd.op     = gqi_pkg::OP_SQRT_INIT;
                state_next = gqi_pkg::ST_SQRT;
                step_next  = '0;
            end
            gqi_pkg::ST_SQRT:
            begin
                cmd.op = gqi_pkg::OP_SQRT;
                if (step_reg == gqi_pkg::SQRT_LAST)
                begin
                    state_next = gqi_pkg::ST_DIV_INIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            gqi_pkg::ST_DIV_INIT:
            begin
                cmd.op     = gqi_pkg::OP_DIV_INIT;
                state_next = gqi_pkg::ST_DIV;
                step_next  = '0;
            end
            gqi_pkg::ST_DIV:
            begin
                cmd.op = gqi_pkg::OP_DIV;
                if (step_reg == gqi_pkg::DIV_LAST)
                begin
                    state_next = gqi_pkg::ST_WRITE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            gqi_pkg::ST_WRITE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = gqi_pkg::OP_WRITE;
                    out_valid_next = 1'b1;
                    state_next     = gqi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gqi_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != gqi_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    `GQI_ASSERT(a_rise_from_write, $rose(out_valid_reg), $past(state_reg == gqi_pkg::ST_WRITE), "result beat without write")
    `GQI_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, (state_reg == gqi_pkg::ST_MUL) && (step_reg == '0), "accept did not start schedule")
    `GQI_ASSERT(a_div_steps, state_reg == gqi_pkg::ST_DIV, step_reg <= gqi_pkg::DIV_LAST, "divide step out of range")
    `GQI_ASSERT_NEXT(a_no_overwrite, (state_reg == gqi_pkg::ST_WRITE) && out_valid_reg && out_stall, state_reg == gqi_pkg::ST_WRITE, "pending result overwritten")

endmodule

// ===== hdl/gqi_dp.sv =====
// datapath: config registers, shared multiplier, bit-serial root and dividers
module gqi_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  gqi_pkg::cmd_t       cmd,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic signed [15:0]  rate_x,
    input  logic signed [15:0]  rate_y,
    input  logic signed [15:0]  rate_z,
    output logic signed [31:0]  att_w,
    output logic signed [31:0]  att_x,
    output logic signed [31:0]  att_y,
    output logic signed [31:0]  att_z
);

    logic [23:0] bias_reg [3];
    logic [31:0] scale_reg, dead_reg, ts_reg;

    logic [15:0] raw_reg [3], raw_next [3];
    logic signed [31:0] quat_reg [4], quat_next [4];
    logic signed [31:0] att_reg [4], att_next [4];
    logic [48:0] mag_reg, mag_next;
    logic [31:0] lohi_reg, lohi_next;
    logic signed [29:0] dang_reg [3], dang_next [3];
    logic signed [63:0] acc_reg [4], acc_next [4];
    logic [63:0] ssq_reg, ssq_next;
    logic [63:0] srem_reg, srem_next, sres_reg, sres_next, sbit_reg, sbit_next;
    logic [31:0] drem_reg [4], drem_next [4];
    logic [30:0] dlow_reg [4], dlow_next [4];
    logic dsat_reg [4], dsat_next [4];
    logic dneg_reg [4], dneg_next [4];
    logic signed [65:0] prod_reg, prod_next;

    gqi_pkg::plan_t plan;
    logic signed [24:0] diff [3];
    logic [24:0] absd [3];
    logic signed [31:0] pc [4];
    logic [31:0] root;
    logic signed [32:0] mul_a, mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg[0] <= 24'd1229;
            bias_reg[1] <= 24'hFFFE45;
            bias_reg[2] <= 24'd71;
            scale_reg   <= 32'd4575429;
            dead_reg    <= 32'd64424509;
            ts_reg      <= 32'd42949673;
            quat_reg[0] <= gqi_pkg::QONE;
            quat_reg[1] <= '0;
            quat_reg[2] <= '0;
            quat_reg[3] <= '0;
        end
        else
        begin
            quat_reg <= quat_next;
            if (cfg_write)
            begin
                case (gqi_pkg::reg_idx_t'(cfg_index))
                    gqi_pkg::REG_BIAS_X:     bias_reg[0] <= cfg_data[23:0];
                    gqi_pkg::REG_BIAS_Y:     bias_reg[1] <= cfg_data[23:0];
                    gqi_pkg::REG_BIAS_Z:     bias_reg[2] <= cfg_data[23:0];
                    gqi_pkg::REG_RATE_SCALE: scale_reg   <= cfg_data;
                    gqi_pkg::REG_DEADBAND:   dead_reg    <= cfg_data;
                    gqi_pkg::REG_TIME_STEP:  ts_reg      <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        att_reg  <= att_next;
        mag_reg  <= mag_next;
        lohi_reg <= lohi_next;
        dang_reg <= dang_next;
        acc_reg  <= acc_next;
        ssq_reg  <= ssq_next;
        srem_reg <= srem_next;
        sres_reg <= sres_next;
        sbit_reg <= sbit_next;
        drem_reg <= drem_next;
        dlow_reg <= dlow_next;
        dsat_reg <= dsat_next;
        dneg_reg <= dneg_next;
        prod_reg <= prod_next;
    end

    assign plan = gqi_pkg::mul_plan(cmd.step);
    assign root = sres_reg[31:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = {raw_reg[i][15], raw_reg[i], 8'b0} - {bias_reg[i][23], bias_reg[i]};
            absd[i] = diff[i][24] ? (~diff[i] + 25'd1) : diff[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            pc[i] = acc_reg[i][61:30];
        end
    end

    // shared signed 33x33 multiplier operands
    always_comb
    begin
        case (plan.kind)
            gqi_pkg::K_SCALE:
            begin
                mul_a = {8'b0, absd[plan.a_idx]};
                mul_b = {1'b0, scale_reg};
            end
            gqi_pkg::K_TLO:
            begin
                mul_a = {1'b0, mag_reg[31:0]};
                mul_b = {1'b0, ts_reg};
            end
            gqi_pkg::K_THI:
            begin
                mul_a = {16'b0, mag_reg[48:32]};
                mul_b = {1'b0, ts_reg};
            end
            gqi_pkg::K_QUAT:
            begin
                mul_a = {quat_reg[plan.a_idx][31], quat_reg[plan.a_idx]};
                mul_b = {{3{dang_reg[plan.d_idx][29]}}, dang_reg[plan.d_idx]};
            end
            default:
            begin
                mul_a = {pc[plan.comp][31], pc[plan.comp]};
                mul_b = mul_a;
            end
        endcase
    end

    always_comb
    begin
        logic [57:0] rnd;
        logic [49:0] hi;
        logic [28:0] hs;
        logic [63:0] st;
        logic [31:0] pa;
        logic [61:0] num;
        logic [62:0] lim;
        logic [32:0] dt;
        logic [32:0] dd;
        logic [31:0] qv;

        raw_next  = raw_reg;
        quat_next = quat_reg;
        att_next  = att_reg;
        mag_next  = mag_reg;
        lohi_next = lohi_reg;
        dang_next = dang_reg;
        acc_next  = acc_reg;
        ssq_next  = ssq_reg;
        srem_next = srem_reg;
        sres_next = sres_reg;
        sbit_next = sbit_reg;
        drem_next = drem_reg;
        dlow_next = dlow_reg;
        dsat_next = dsat_reg;
        dneg_next = dneg_reg;
        prod_next = prod_reg;
        rnd = '0;
        hi  = '0;
        hs  = '0;
        st  = '0;
        pa  = '0;
        num = '0;
        lim = '0;
        dt  = '0;
        dd  = '0;
        qv  = '0;

        case (cmd.op)
            gqi_pkg::OP_LOAD:
            begin
                raw_next[0] = rate_x;
                raw_next[1] = rate_y;
                raw_next[2] = rate_z;
                for (int i = 0; i < 4; i++)
                begin
                    // old component in Q.60 plus half an output lsb
                    acc_next[i] = {{2{quat_reg[i][31]}}, quat_reg[i], 30'b0}
                                  + 64'sh0000_0000_2000_0000;
                end
                ssq_next = '0;
            end
            gqi_pkg::OP_MUL:
            begin
                prod_next = mul_a * mul_b;
            end
            gqi_pkg::OP_ACC:
            begin
                case (plan.kind)
                    gqi_pkg::K_SCALE:
                    begin
                        rnd = {1'b0, prod_reg[56:0]} + 58'd128;
                        mag_next = rnd[56:8];
                    end
                    gqi_pkg::K_TLO:
                    begin
                        lohi_next = prod_reg[63:32];
                    end
                    gqi_pkg::K_THI:
                    begin
                        hi = {1'b0, prod_reg[48:0]} + {18'b0, lohi_reg};
                        hs = (hi[49:3] > gqi_pkg::HALF_MAX) ? gqi_pkg::HALF_MAX[28:0] : hi[31:3];
                        if (mag_reg < {17'b0, dead_reg})
                        begin
                            hs = '0;
                        end
                        dang_next[plan.a_idx] = diff[plan.a_idx][24] ? (30'sd0 - {1'b0, hs})
                                                                     : {1'b0, hs};
                    end
                    gqi_pkg::K_QUAT:
                    begin
                        if (plan.neg)
                        begin
                            acc_next[plan.comp] = acc_reg[plan.comp] - prod_reg[63:0];
                        end
                        else
                        begin
                            acc_next[plan.comp] = acc_reg[plan.comp] + prod_reg[63:0];
                        end
                    end
                    default:
                    begin
                        ssq_next = ssq_reg + prod_reg[63:0];
                    end
                endcase
            end
            gqi_pkg::OP_SQRT_INIT:
            begin
                srem_next = ssq_reg;
                sres_next = '0;
                sbit_next = 64'h4000_0000_0000_0000;
            end
            gqi_pkg::OP_SQRT:
            begin
                st = sres_reg + sbit_reg;
                if (srem_reg >= st)
                begin
                    srem_next = srem_reg - st;
                    sres_next = (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_next = sres_reg >> 1;
                end
                sbit_next = sbit_reg >> 2;
            end
            gqi_pkg::OP_DIV_INIT:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    pa  = pc[i][31] ? (~pc[i] + 32'd1) : pc[i];
                    num = {pa, 30'b0} + {31'b0, root[31:1]};
                    // quotient above one when num reaches (2^30 + 1) * r
                    lim = {1'b0, root, 30'b0} + {31'b0, root};
                    dsat_next[i] = ({1'b0, num} >= lim);
                    drem_next[i] = {1'b0, num[61:31]};
                    dlow_next[i] = num[30:0];
                    dneg_next[i] = pc[i][31];
                end
            end
            gqi_pkg::OP_DIV:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    dt = {drem_reg[i], dlow_reg[i][30]};
                    dd = dt - {1'b0, root};
                    if (dt >= {1'b0, root})
                    begin
                        drem_next[i] = dd[31:0];
                        dlow_next[i] = {dlow_reg[i][29:0], 1'b1};
                    end
                    else
                    begin
                        drem_next[i] = dt[31:0];
                        dlow_next[i] = {dlow_reg[i][29:0], 1'b0};
                    end
                end
            end
            gqi_pkg::OP_WRITE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    qv = dsat_reg[i] ? gqi_pkg::QONE : {1'b0, dlow_reg[i]};
                    quat_next[i] = dneg_reg[i] ? (32'sd0 - qv) : qv;
                end
                // zero norm restarts from the identity
                if (root == '0)
                begin
                    quat_next[0] = gqi_pkg::QONE;
                    quat_next[1] = '0;
                    quat_next[2] = '0;
                    quat_next[3] = '0;
                end
                att_next = quat_next;
            end
            default:
            begin
            end
        endcase
    end

    assign att_w = att_reg[0];
    assign att_x = att_reg[1];
    assign att_y = att_reg[2];
    assign att_z = att_reg[3];

endmodule

// ===== hdl/gyro_quaternion_integrator.sv =====
// an accepted input beat runs the whole schedule below before its result is written;
// in_stall holds off the next beat until then: 25 products through one shared
//   multiplier, a 32-step square root and 31-step dividers in four lanes
// a new input beat is taken while a finished result still waits on out_stall
// reset: asynchronous active low; attitude returns to identity, registers to defaults
module gyro_quaternion_integrator
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] att_w,
    output logic signed [31:0] att_x,
    output logic signed [31:0] att_y,
    output logic signed [31:0] att_z
);

    gqi_pkg::cmd_t cmd;

    gqi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    gqi_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rate_x    (rate_x),
        .rate_y    (rate_y),
        .rate_z    (rate_z),
        .att_w     (att_w),
        .att_x     (att_x),
        .att_y     (att_y),
        .att_z     (att_z)
    );

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the gyro quaternion integrator
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY     = 130;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    typedef struct {
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
    } gyro_sample_t;

    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } attitude_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;

    gyro_sample_t sample_queue[$];
    attitude_t    attitude_queue[$];
    gyro_sample_t cur_sample;

    // predictor copy of registers and attitude
    logic [23:0]        bias_x_m, bias_y_m, bias_z_m;
    logic [31:0]        scale_m, dband_m, tstep_m;
    logic signed [31:0] qw_m, qx_m, qy_m, qz_m;

    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          stall_left;
    longint      cycle_count;
    bit          failed;

    gyro_quaternion_integrator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rate_x    (rate_x),
        .rate_y    (rate_y),
        .rate_z    (rate_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .att_w     (att_w),
        .att_x     (att_x),
        .att_y     (att_y),
        .att_z     (att_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // signed half angle in Q.30 for one axis
    function automatic longint half_angle(input logic [15:0] raw, input logic [23:0] bias);
        longint       diff;
        logic [63:0]  a;
        logic [127:0] mag;
        logic [127:0] h;
        diff = longint'($signed(raw)) * 256 - longint'($signed(bias));
        a = (diff < 0) ? 64'(-diff) : 64'(diff);
        mag = ({64'd0, a} * {96'd0, scale_m} + 128'd128) >> 8;
        if (mag < {96'd0, dband_m})
            return 0;
        h = (mag * {96'd0, tstep_m}) >> 35;
        if (h > 128'h1000_0000)
            h = 128'h1000_0000;
        return (diff < 0) ? -longint'(h[63:0]) : longint'(h[63:0]);
    endfunction

    function automatic longint euler_comp(input longint q, input longint t);
        longint acc;
        acc = q * 64'sd1073741824 + t + 64'sd536870912;
        return acc >>> 30;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] unit_comp(input longint p, input logic [63:0] r);
        logic [63:0] a;
        logic [63:0] v;
        a = (p < 0) ? 64'(-p) : 64'(p);
        v = ((a << 30) + (r >> 1)) / r;
        if (v > 64'd1073741824)
            v = 64'd1073741824;
        return (p < 0) ? -$signed(v[31:0]) : $signed(v[31:0]);
    endfunction

    function automatic attitude_t integrate_attitude(input gyro_sample_t s);
        longint      dx, dy, dz, q0, q1, q2, q3;
        longint      p[4];
        logic [63:0] sum;
        logic [63:0] r;
        logic [63:0] a;
        attitude_t   res;
        dx = half_angle(s.rx, bias_x_m);
        dy = half_angle(s.ry, bias_y_m);
        dz = half_angle(s.rz, bias_z_m);
        q0 = qw_m; q1 = qx_m; q2 = qy_m; q3 = qz_m;
        p[0] = euler_comp(q0, -q1 * dx - q2 * dy - q3 * dz);
        p[1] = euler_comp(q1, q0 * dx + q2 * dz - q3 * dy);
        p[2] = euler_comp(q2, q0 * dy - q1 * dz + q3 * dx);
        p[3] = euler_comp(q3, q0 * dz + q1 * dy - q2 * dx);
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            a = (p[i] < 0) ? 64'(-p[i]) : 64'(p[i]);
            sum = sum + a * a;
        end
        r = int_sqrt(sum);
        if (r == 0)
        begin
            qw_m = gqi_pkg::QONE; qx_m = 0; qy_m = 0; qz_m = 0;
        end
        else
        begin
            qw_m = unit_comp(p[0], r);
            qx_m = unit_comp(p[1], r);
            qy_m = unit_comp(p[2], r);
            qz_m = unit_comp(p[3], r);
        end
        res.w = qw_m; res.x = qx_m; res.y = qy_m; res.z = qz_m;
        return res;
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            rate_x     <= '0;
            rate_y     <= '0;
            rate_z     <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                attitude_queue.push_back(integrate_attitude(cur_sample));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_queue.size() > 0)
                begin
                    cur_sample = sample_queue.pop_front();
                    rate_x   <= cur_sample.rx;
                    rate_y   <= cur_sample.ry;
                    rate_z   <= cur_sample.rz;
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches between none, random and mostly stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            stall_left <= 200;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(50, 2000);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ($urandom_range(0, 15) < 13);
            endcase
        end
    end

    // check each result beat against the oldest predicted attitude
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (attitude_queue.size() == 0)
            begin
                $display("%0t: unexpected result beat %0d %0d %0d %0d",
                         $time, att_w, att_x, att_y, att_z);
                failed = 1'b1;
            end
            else
            begin
                attitude_t e;
                e = attitude_queue.pop_front();
                if (att_w !== e.w)
                begin
                    $display("%0t: att_w expected %0d actual %0d", $time, e.w, att_w);
                    failed = 1'b1;
                end
                if (att_x !== e.x)
                begin
                    $display("%0t: att_x expected %0d actual %0d", $time, e.x, att_x);
                    failed = 1'b1;
                end
                if (att_y !== e.y)
                begin
                    $display("%0t: att_y expected %0d actual %0d", $time, e.y, att_y);
                    failed = 1'b1;
                end
                if (att_z !== e.z)
                begin
                    $display("%0t: att_z expected %0d actual %0d", $time, e.z, att_z);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            gqi_pkg::REG_BIAS_X:     bias_x_m = val[23:0];
            gqi_pkg::REG_BIAS_Y:     bias_y_m = val[23:0];
            gqi_pkg::REG_BIAS_Z:     bias_z_m = val[23:0];
            gqi_pkg::REG_RATE_SCALE: scale_m  = val;
            gqi_pkg::REG_DEADBAND:   dband_m  = val;
            gqi_pkg::REG_TIME_STEP:  tstep_m  = val;
            default:                 ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
                             input logic [31:0] sc, input logic [31:0] db, input logic [31:0] ts);
        write_reg(gqi_pkg::REG_BIAS_X, bx);
        write_reg(gqi_pkg::REG_BIAS_Y, by);
        write_reg(gqi_pkg::REG_BIAS_Z, bz);
        write_reg(gqi_pkg::REG_RATE_SCALE, sc);
        write_reg(gqi_pkg::REG_DEADBAND, db);
        write_reg(gqi_pkg::REG_TIME_STEP, ts);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, $urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic add_sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        gyro_sample_t s;
        s.rx = x;
        s.ry = y;
        s.rz = z;
        sample_queue.push_back(s);
    endtask

    function automatic logic [15:0] pick_rate();
        int sel;
        sel = $urandom_range(0, 5);
        if (sel < 2)
            return 16'($urandom);
        else if (sel < 5)
            return 16'($signed($urandom_range(0, 400)) - 200);
        else
            return 16'($signed($urandom_range(0, 8000)) - 4000);
    endfunction

    task automatic drain();
        while (sample_queue.size() != 0 || in_valid || attitude_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    initial
    begin
        failed      = 1'b0;
        cycle_count = 0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        bias_x_m = 24'd1229;
        bias_y_m = 24'(-443);
        bias_z_m = 24'd71;
        scale_m  = 32'd4575429;
        dband_m  = 32'd64424509;
        tstep_m  = 32'd42949673;
        qw_m = gqi_pkg::QONE; qx_m = 0; qy_m = 0; qz_m = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats on reset registers: extremes, zero, below and above deadband
        add_sample(16'h7fff, 16'h8000, 16'h0000);
        add_sample(16'h8000, 16'h7fff, 16'hffff);
        add_sample(16'h0000, 16'h0000, 16'h0000);
        add_sample(16'd5, 16'hfffe, 16'd1);
        add_sample(16'd30, 16'hffe0, 16'd20);
        add_sample(16'hffff, 16'd1, 16'h7fff);
        for (int i = 0; i < 300; i++)
            add_sample(pick_rate(), pick_rate(), pick_rate());
        drain();

        // huge step: half angles saturate
        write_all(32'h7fffff, 32'h800000, 32'h0, 32'hffffffff, 32'h0, 32'hffffffff);
        add_sample(16'h7fff, 16'h7fff, 16'h7fff);
        add_sample(16'h8000, 16'h8000, 16'h8000);
        add_sample(16'h7fff, 16'h8000, 16'h7fff);
        add_sample(16'h0000, 16'h0000, 16'h0000);
        add_sample(16'h1234, 16'hedcb, 16'h0001);
        for (int i = 0; i < 120; i++)
            add_sample(pick_rate(), pick_rate(), pick_rate());
        drain();

        // zero scale and zero step, full deadband
        write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'hffffffff, 32'h0);
        add_sample(16'h7fff, 16'h8000, 16'h1111);
        add_sample(16'h8000, 16'h7fff, 16'heeee);
        for (int i = 0; i < 40; i++)
            add_sample(pick_rate(), pick_rate(), pick_rate());
        drain();

        write_all(32'h800000, 32'h7fffff, 32'hffffff, 32'hffffffff, 32'h0, 32'h0);
        for (int i = 0; i < 40; i++)
            add_sample(pick_rate(), pick_rate(), pick_rate());
        drain();

        // random register settings
        for (int ph = 0; ph < 8; ph++)
        begin
            write_all($urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 2000,
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 2000,
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000) - 2000,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50000000),
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000000),
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400000000));
            for (int i = 0; i < 150; i++)
                add_sample(pick_rate(), pick_rate(), pick_rate());
            drain();
        end

        if (!failed)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
